// File: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, character codes, status codes and the alphabet map.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [6:0] SEXTET_NONE = 7'd64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } group_t;

  // Maps an alphabet character to 0..63; anything else gives 64.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + 8'd26;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0 + 8'd52;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else begin
      d = {1'b0, SEXTET_NONE};
    end
    return d[6:0];
  endfunction

endpackage

// File: design/b64d_char_if.sv
// ----------------------------------------------------------------------------
// Base64 character channel
// Valid/ready channel carrying one text character and its end flag.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       end_of_code;

  modport source (output valid, output code_char, output end_of_code, input ready);
  modport sink (input valid, input code_char, input end_of_code, output ready);
endinterface

// File: design/b64d_byte_if.sv
// ----------------------------------------------------------------------------
// Base64 result channel
// Valid/ready channel carrying one decoded byte with its framing and status.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  output status, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                input status, output ready);
endinterface

// File: design/b64d_decode.sv
// ----------------------------------------------------------------------------
// Base64 character decoder
// Holds the group state and turns one registered character into a group of
// up to three results.
// ----------------------------------------------------------------------------
module b64d_decode
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       skip_line_breaks,
  input  logic       fire,
  input  logic [7:0] code_char,
  input  logic       end_of_code,
  output group_t     grp
);

  logic [1:0]  group_position;
  logic [17:0] bit_accumulator;
  logic [1:0]  pad_count;
  logic        error_seen;

  logic [1:0]  group_position_next;
  logic [17:0] bit_accumulator_next;
  logic [1:0]  pad_count_next;
  logic        error_seen_next;

  logic        skip;
  logic        is_pad;
  logic        bad;
  logic [6:0]  v_raw;
  logic [5:0]  v;
  logic [1:0]  pad_upd;
  logic        err_upd;
  logic [1:0]  pos_upd;
  logic        emit;
  logic [1:0]  cnt_b;
  logic [1:0]  n;
  logic [1:0]  status;
  logic [7:0]  b [3];

  always_comb begin
    skip    = skip_line_breaks && (code_char == CH_CR || code_char == CH_LF);
    is_pad  = code_char == CH_PAD;
    v_raw   = sextet_of(code_char);
    bad     = is_pad ? (group_position < 2'd2) : (v_raw[6] || pad_count != 2'd0);
    v       = (bad || is_pad) ? 6'd0 : v_raw[5:0];
    pad_upd = pad_count;
    err_upd = error_seen;
    pos_upd = group_position;
    emit    = 1'b0;

    group_position_next  = group_position;
    bit_accumulator_next = bit_accumulator;
    pad_count_next       = pad_count;
    error_seen_next      = error_seen;

    b[0] = {bit_accumulator[17:12], bit_accumulator[11:10]};
    b[1] = {bit_accumulator[9:6], bit_accumulator[5:2]};
    b[2] = {bit_accumulator[1:0], v};

    if (!skip) begin
      if (is_pad && !bad) begin
        pad_upd = pad_count + 2'd1;
      end
      err_upd = error_seen | bad;
      if (group_position == 2'd3) begin
        emit                 = !err_upd;
        pos_upd              = 2'd0;
        group_position_next  = 2'd0;
        bit_accumulator_next = 18'd0;
        pad_count_next       = 2'd0;
      end else begin
        pos_upd              = group_position + 2'd1;
        group_position_next  = pos_upd;
        bit_accumulator_next = {bit_accumulator[11:0], v};
        pad_count_next       = pad_upd;
      end
      error_seen_next = err_upd;
    end

    cnt_b = 2'd3 - ((pad_upd > 2'd2) ? 2'd2 : pad_upd);
    grp   = '0;
    n     = 2'd0;
    if (emit) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt_b) begin
          grp.res[i].data_byte  = b[i];
          grp.res[i].byte_valid = 1'b1;
        end
      end
      n = cnt_b;
    end

    status = err_upd ? ST_INVALID : ((pos_upd != 2'd0) ? ST_LENGTH : ST_OK);
    if (end_of_code) begin
      if (status == ST_OK && n != 2'd0) begin
        grp.res[n - 2'd1].last = 1'b1;
      end else begin
        grp.res[n].data_byte  = 8'd0;
        grp.res[n].byte_valid = 1'b0;
        grp.res[n].last       = 1'b1;
        grp.res[n].status     = status;
        n = n + 2'd1;
      end
      group_position_next  = 2'd0;
      bit_accumulator_next = 18'd0;
      pad_count_next       = 2'd0;
      error_seen_next      = 1'b0;
    end
    grp.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position  <= 2'd0;
      bit_accumulator <= 18'd0;
      pad_count       <= 2'd0;
      error_seen      <= 1'b0;
    end else if (fire) begin
      group_position  <= group_position_next;
      bit_accumulator <= bit_accumulator_next;
      pad_count       <= pad_count_next;
      error_seen      <= error_seen_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_code |=> group_position == 2'd0 && pad_count == 2'd0 && !error_seen)
    else $error("stream state not cleared after end of code");

  a_pad_needs_pos: assert property (@(posedge clk) disable iff (rst)
    pad_count != 2'd0 |-> group_position >= 2'd3)
    else $error("padding recorded before the third position");

endmodule

// File: design/b64d_serializer.sv
// ----------------------------------------------------------------------------
// Base64 result serializer
// Holds one decoded group and hands its results out one beat at a time.
// ----------------------------------------------------------------------------
module b64d_serializer
  import b64d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  group_t       grp,
  output logic         group_ready,
  b64d_byte_if.source  byte_out
);

  result_t [2:0] slots;
  logic [1:0]    cnt;
  logic          pop;

  assign pop         = byte_out.valid && byte_out.ready;
  assign group_ready = (cnt == 2'd0) || (cnt == 2'd1 && pop);

  assign byte_out.valid      = cnt != 2'd0;
  assign byte_out.data_byte  = slots[0].data_byte;
  assign byte_out.byte_valid = slots[0].byte_valid;
  assign byte_out.last       = slots[0].last;
  assign byte_out.status     = slots[0].status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= grp.res;
    end else if (pop) begin
      slots <= {12'd0, slots[2], slots[1]};
    end
  end

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    byte_out.valid && byte_out.last |-> cnt == 2'd1)
    else $error("result marked last while more results are pending");

  a_status_on_close: assert property (@(posedge clk) disable iff (rst)
    byte_out.valid && byte_out.status != ST_OK |-> byte_out.last && !byte_out.byte_valid)
    else $error("error status outside a closing beat");

  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    pop && cnt > 2'd1 |=> byte_out.valid)
    else $error("pending results lost while draining a group");

endmodule

// File: design/base64_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a stream of Base64 characters into bytes with a closing status.
// ----------------------------------------------------------------------------
// The block accepts one character per cycle into an input register. The
// decoder maps the character and updates the group state at the edge where
// the character leaves that register, and any results it gives go to the
// serializer at the same edge. A result of a character therefore passes
// the input register and the serializer before it can be taken. Results
// leave one per beat, and a full group of four characters gives three
// output beats, so characters can follow back to back at one per cycle
// while the receiver keeps up. A character that gives no result passes
// straight through. A character that gives results waits in the input
// register, and holds off the input, while the serializer still holds
// results that do not leave in that cycle.
module base64_stream_decoder_unit
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  b64d_char_if.sink   code_in,
  b64d_byte_if.source byte_out
);

  logic       skip_line_breaks;
  logic       held;
  logic [7:0] code_char;
  logic       end_of_code;
  logic       group_ready;
  logic       fire;
  logic       load;
  group_t     grp;

  assign fire          = held && (group_ready || grp.count == 2'd0);
  assign load          = fire && grp.count != 2'd0;
  assign code_in.ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_line_breaks <= 1'b1;
    end else if (cfg_write) begin
      skip_line_breaks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (code_in.valid && code_in.ready) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (code_in.valid && code_in.ready) begin
      code_char   <= code_in.code_char;
      end_of_code <= code_in.end_of_code;
    end
  end

  b64d_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .skip_line_breaks (skip_line_breaks),
    .fire             (fire),
    .code_char        (code_char),
    .end_of_code      (end_of_code),
    .grp              (grp)
  );

  b64d_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .grp         (grp),
    .group_ready (group_ready),
    .byte_out    (byte_out)
  );

endmodule

// File: tb/b64d_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder stream checker
// Watches the character and byte channels of the decoder, predicts the bytes
// and closing status of every accepted character, and compares each byte
// beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module b64d_stream_checker
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  b64d_char_if        chars,
  b64d_byte_if        bytes,
  output int unsigned mismatches,
  output int unsigned pending
);

  logic        skip_breaks;
  logic [1:0]  grp_pos;
  logic [17:0] sextets;
  logic [1:0]  pad_seen;
  logic        bad_seen;
  int unsigned beats_seen;
  result_t     expected_bytes[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: beat %0d: %s", $realtime, beats_seen, msg);
    mismatches++;
  endtask

  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) return 7'(c - CH_UPPER_A);
    if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) return 7'(c - CH_LOWER_A + 8'd26);
    if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) return 7'(c - CH_DIGIT_0 + 8'd52);
    case (c)
      CH_PLUS:  return 7'd62;
      CH_SLASH: return 7'd63;
      default:  return SEXTET_NONE;
    endcase
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eoc);
    logic [6:0]      v;
    logic [5:0]      n0;
    logic [5:0]      n1;
    logic [5:0]      n2;
    logic [2:0][7:0] b;
    logic [1:0]      st;
    int              keep;
    int              made;
    result_t         r;
    made = 0;
    if (!(skip_breaks && (c == CH_CR || c == CH_LF))) begin
      v = char_value(c);
      if (c == CH_PAD) begin
        if (grp_pos < 2'd2) begin
          bad_seen = 1'b1;
        end else begin
          pad_seen = pad_seen + 2'd1;
        end
        v = '0;
      end else if (v == SEXTET_NONE || pad_seen != 2'd0) begin
        bad_seen = 1'b1;
        v = '0;
      end
      if (grp_pos == 2'd3) begin
        n0 = sextets[17:12];
        n1 = sextets[11:6];
        n2 = sextets[5:0];
        b[0] = {n0, n1[5:4]};
        b[1] = {n1[3:0], n2[5:2]};
        b[2] = {n2[1:0], v[5:0]};
        keep = 3 - ((pad_seen > 2'd2) ? 2 : int'(pad_seen));
        if (!bad_seen) begin
          for (int i = 0; i < keep; i++) begin
            expected_bytes.push_back('{data_byte: b[i], byte_valid: 1'b1, last: 1'b0,
                                       status: ST_OK});
            made++;
          end
        end
        grp_pos = '0;
        sextets = '0;
        pad_seen = '0;
      end else begin
        sextets = {sextets[11:0], v[5:0]};
        grp_pos = grp_pos + 2'd1;
      end
    end
    if (eoc) begin
      st = bad_seen ? ST_INVALID : ((grp_pos != 2'd0) ? ST_LENGTH : ST_OK);
      if (st == ST_OK && made > 0) begin
        r = expected_bytes.pop_back();
        r.last = 1'b1;
        expected_bytes.push_back(r);
      end else begin
        expected_bytes.push_back('{data_byte: 8'd0, byte_valid: 1'b0, last: 1'b1,
                                   status: st});
      end
      grp_pos = '0;
      sextets = '0;
      pad_seen = '0;
      bad_seen = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      skip_breaks = 1'b1;
      grp_pos = '0;
      sextets = '0;
      pad_seen = '0;
      bad_seen = 1'b0;
      expected_bytes.delete();
      mismatches = 0;
      beats_seen = 0;
    end else begin
      if (cfg_write) begin
        skip_breaks = cfg_data;
      end
      if (chars.valid && chars.ready) begin
        decode_char(chars.code_char, chars.end_of_code);
      end
      if (bytes.valid && bytes.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data=%h valid=%b last=%b status=%0d",
                                    bytes.data_byte, bytes.byte_valid, bytes.last,
                                    bytes.status));
        end else begin
          want = expected_bytes.pop_front();
          if (bytes.data_byte !== want.data_byte || bytes.byte_valid !== want.byte_valid ||
              bytes.last !== want.last || bytes.status !== want.status) begin
            report_mismatch($sformatf(
              "got data=%h valid=%b last=%b status=%0d, expected data=%h valid=%b last=%b status=%0d",
              bytes.data_byte, bytes.byte_valid, bytes.last, bytes.status,
              want.data_byte, want.byte_valid, want.last, want.status));
          end
        end
        beats_seen++;
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Drives directed and random Base64 messages, some clean and some broken,
// through the decoder under both line-break settings, with random gaps on
// the character side and random stalls, including one long hold-off, on the
// byte side. A checker beside the decoder predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb
  import b64d_pkg::*;
();

  typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SELDOM} rx_mode_t;
  typedef enum {MSG_CLEAN, MSG_CORRUPT, MSG_SHORT, MSG_NOISE} msg_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent = 0;
  int          burst_left = 0;
  bit          skip_now = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  b64d_char_if code_in ();
  b64d_byte_if byte_out ();

  base64_stream_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .code_in  (code_in),
    .byte_out (byte_out)
  );

  b64d_stream_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .chars     (code_in),
    .bytes     (byte_out),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] alpha_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'(CH_UPPER_A + r);
    if (r < 52) return 8'(CH_LOWER_A + r - 26);
    if (r < 62) return 8'(CH_DIGIT_0 + r - 52);
    return (r == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0:       return CH_PAD;
      1:       return alpha_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_char(input logic [7:0] c, input logic eoc);
    if (burst_left <= 0) begin
      code_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    code_in.valid <= 1'b1;
    code_in.code_char <= c;
    code_in.end_of_code <= eoc;
    @(posedge clk);
    while (!code_in.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (!(skip_now && (c == CH_CR || c == CH_LF))) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_message();
    logic [7:0] text[$];
    logic [7:0] stream[$];
    msg_kind_t  kind;
    int         groups;
    int         pads;
    case ($urandom_range(0, 9))
      7:       kind = MSG_CORRUPT;
      8:       kind = MSG_SHORT;
      9:       kind = MSG_NOISE;
      default: kind = MSG_CLEAN;
    endcase
    groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (int g = 0; g < 4 * groups; g++) text.push_back(alpha_char());
    pads = $urandom_range(0, 2);
    for (int k = 0; k < pads; k++) text[text.size() - 1 - k] = CH_PAD;
    case (kind)
      MSG_CORRUPT: text[$urandom_range(0, text.size() - 1)] = noise_char();
      MSG_SHORT:   repeat ($urandom_range(1, 3)) void'(text.pop_back());
      MSG_NOISE: begin
        text.delete();
        repeat ($urandom_range(1, 6)) text.push_back(noise_char());
      end
      default: ;
    endcase
    foreach (text[i]) begin
      stream.push_back(text[i]);
      if ($urandom_range(0, 9) == 0) stream.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
    if ($urandom_range(0, 9) == 0) stream.push_back(CH_LF);
    foreach (stream[i]) send_char(stream[i], i == stream.size() - 1);
  endtask

  // Lets the decoder drain; characters that give no byte may still be in flight.
  task automatic settle();
    code_in.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_line_breaks(input logic value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    skip_now = value;
    @(negedge clk);
  endtask

  initial begin : receiver
    rx_mode_t mode;
    byte_out.ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        if (hold_off_req && !hold_off_done) begin
          byte_out.ready <= 1'b0;
          repeat (300) @(negedge clk);
          hold_off_done = 1'b1;
        end else begin
          case (mode)
            RX_ALWAYS: byte_out.ready <= 1'b1;
            RX_HALF:   byte_out.ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: byte_out.ready <= ($urandom_range(0, 3) != 0);
            default:   byte_out.ready <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    code_in.valid <= 1'b0;
    code_in.code_char <= 8'd0;
    code_in.end_of_code <= 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("TWFu");
    send_text("TQ==");
    send_text("/+\r9z");
    send_text("=");
    send_text("AB=C");
    send_text("AB");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(CH_LF, 1'b1);
    settle();
    write_line_breaks(1'b0);
    send_char(CH_CR, 1'b1);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_line_breaks(1'b1);
        1:       write_line_breaks(1'b0);
        2:       write_line_breaks(1'($urandom_range(0, 1)));
        default: write_line_breaks(1'b1);
      endcase
      if (phase == 1) hold_off_req = 1'b1;
      target = items_sent + 75;
      while (items_sent < target) send_message();
      settle();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[base64_stream_decoder_unit] OK");
    end else begin
      $display("[base64_stream_decoder_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[base64_stream_decoder_unit] ERROR");
    $finish;
  end

endmodule
